// ===== hdl/cdb_pkg.sv =====
// Shared types, codes and constants of the circular deque buffer.
package cdb_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 4;

    // operation codes carried in the func field
    localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
    localparam logic [1:0] FUNC_PUSH_BACK  = 2'd1;
    localparam logic [1:0] FUNC_POP_FRONT  = 2'd2;
    localparam logic [1:0] FUNC_POP_BACK   = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] EMPTY_POP_VALUE = -32'sd1;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
        logic                     is_full;
        logic                     is_empty;
    } out_item_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_READ
    } ctl_state_t;

    typedef struct packed {
        logic accept;
        logic load_pop;
    } ctl_cmd_t;

    typedef struct packed {
        logic needs_read;
    } dp_status_t;

endpackage

// ===== hdl/cdb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/cdb_datapath.sv =====
// Pointers, count, ring storage and result register of the deque.
module cdb_datapath
    import cdb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ctl_cmd_t   cmd,
    output dp_status_t status,
    input  in_item_t   s_data,
    output out_item_t  m_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    out_item_t        res_reg, res_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic             is_push;
    logic             is_front;
    logic             at_empty;
    logic             at_full;
    logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;

    assign is_push  = ~s_data.func[1];
    assign is_front = (s_data.func == FUNC_PUSH_FRONT) || (s_data.func == FUNC_POP_FRONT);
    assign at_empty = (count_reg == '0);
    assign at_full  = (count_reg == FULL_CNT);

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - IDX_W'(1);
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - IDX_W'(1);

    assign status.needs_read = ~is_push & ~at_empty;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = is_front ? head_reg : tail_reg;
        res_next   = res_reg;
        if (cmd.accept) begin
            res_next.pop_value = '0;
            res_next.status    = STATUS_DONE;
            if (is_push) begin
                if (at_full) begin
                    res_next.status = STATUS_FULL;
                end else begin
                    wr_en = 1'b1;
                    if (at_empty) begin
                        // restart both ends at slot zero
                        head_next = '0;
                        tail_next = '0;
                        wr_addr   = '0;
                    end else if (is_front) begin
                        head_next = head_dec;
                        wr_addr   = head_dec;
                    end else begin
                        tail_next = tail_inc;
                        wr_addr   = tail_inc;
                    end
                    count_next = count_reg + CNT_W'(1);
                end
            end else begin
                if (at_empty) begin
                    res_next.status    = STATUS_EMPTY;
                    res_next.pop_value = EMPTY_POP_VALUE;
                end else begin
                    rd_en = 1'b1;
                    // hold the pointers on the last entry
                    if (count_reg != CNT_W'(1)) begin
                        if (is_front) begin
                            head_next = head_inc;
                        end else begin
                            tail_next = tail_dec;
                        end
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            res_next.occupancy = OCC_W'(count_next);
            res_next.is_full   = (count_next == FULL_CNT);
            res_next.is_empty  = (count_next == '0);
        end else if (cmd.load_pop) begin
            res_next.pop_value = rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_data = res_reg;

    cdb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== hdl/cdb_controller.sv =====
// Handshake and sequencing state machine of the deque.
module cdb_controller
    import cdb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    ctl_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE: begin
                if (cmd.accept && status.needs_read) begin
                    state_next = CTL_READ;
                end
            end
            CTL_READ: begin
                state_next = CTL_IDLE;
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = (state_reg == CTL_IDLE) && (!m_valid_reg || m_ready);
        cmd.accept   = s_valid && s_ready;
        cmd.load_pop = (state_reg == CTL_READ);
        m_valid_next = m_valid_reg;
        priority if (cmd.load_pop || (cmd.accept && !status.needs_read)) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CTL_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== hdl/circular_deque_buffer.sv =====
// Top level of the circular deque buffer.
// Double-ended queue of DEPTH signed 32-bit words kept in a ring RAM. Each input
// transfer carries one operation (push front, push back, pop front, pop back) and
// yields exactly one result transfer with the popped word, a status, the count
// after the operation and full/empty flags. A push or a rejected pop is registered
// straight into the result; a pop that returns a word goes through the read state,
// since the ring RAM's read data is registered. One operation is in flight at a time;
// a finished result sits in an output register, and the next operation is taken while
// it is being drained. The ring needs no clearing after reset.
module circular_deque_buffer
    import cdb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    cdb_controller u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cdb_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule
